// File: src/scd_pkg.sv
// Shared types, constants and tables for the concentric disk mapping unit.
package scd_pkg;

	localparam int FracBitsDefault = 15;
	localparam int RotStepsDefault = 16;
	localparam int AngBits = 29;
	localparam int Guard = 2;
	localparam int DivBits = AngBits + 1;
	localparam logic [29:0] GainQ30 = 30'd652032874;

	typedef struct packed {
		logic [15:0] square_u;
		logic [15:0] square_v;
	} scd_in_t;

	typedef struct packed {
		logic signed [15:0] disk_x;
		logic signed [15:0] disk_y;
	} scd_out_t;

	function automatic logic [31:0] step_angle(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'd536870912;
			1: t = 32'd316933406;
			2: t = 32'd167458907;
			3: t = 32'd85004756;
			4: t = 32'd42667331;
			5: t = 32'd21354465;
			6: t = 32'd10679838;
			7: t = 32'd5340245;
			8: t = 32'd2670163;
			9: t = 32'd1335087;
			10: t = 32'd667544;
			11: t = 32'd333772;
			12: t = 32'd166886;
			13: t = 32'd83443;
			14: t = 32'd41722;
			15: t = 32'd20861;
			16: t = 32'd10430;
			17: t = 32'd5215;
			18: t = 32'd2608;
			19: t = 32'd1304;
			20: t = 32'd652;
			21: t = 32'd326;
			22: t = 32'd163;
			23: t = 32'd81;
			24: t = 32'd41;
			25: t = 32'd20;
			26: t = 32'd10;
			27: t = 32'd5;
			28: t = 32'd3;
			29: t = 32'd1;
			30: t = 32'd1;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

endpackage

// File: src/scd_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
module scd_divider #(
	parameter int NumBits = 16,
	parameter int QBits = 30,
	parameter int TagBits = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic vin,
	input  logic [NumBits-1:0] num,
	input  logic [NumBits-1:0] den,
	input  logic [TagBits-1:0] tag_in,
	output logic vout,
	output logic [QBits-1:0] quo,
	output logic [TagBits-1:0] tag_out
);
	// Past the first stage the partial remainder stays below den, given num <= den and den nonzero.
	logic [NumBits-1:0] rem_q [QBits+1];
	logic [NumBits-1:0] den_q [QBits+1];
	logic [QBits-1:0] quo_q [QBits+1];
	logic [TagBits-1:0] tag_q [QBits+1];
	logic vld_q [QBits+1];

	always_comb begin
		rem_q[0] = num;
		den_q[0] = den;
		quo_q[0] = '0;
		tag_q[0] = tag_in;
		vld_q[0] = vin;
	end

	// The first stage gives the integer bit, so the quotient is num * 2^(QBits-1) / den.
	for (genvar k = 0; k < QBits; k++) begin : g_st
		logic [NumBits:0] trial;
		logic [NumBits:0] dif;
		logic [NumBits-1:0] nrem;
		logic qb;
		always_comb begin
			trial = (k == 0) ? {1'b0, rem_q[k]} : {rem_q[k], 1'b0};
			dif = trial - {1'b0, den_q[k]};
			qb = !dif[NumBits];
			nrem = qb ? dif[NumBits-1:0] : trial[NumBits-1:0];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else if (adv) begin
				vld_q[k+1] <= vld_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[k+1] <= nrem;
				den_q[k+1] <= den_q[k];
				quo_q[k+1] <= {quo_q[k][QBits-2:0], qb};
				tag_q[k+1] <= tag_q[k];
			end
		end
	end

	assign vout = vld_q[QBits];
	assign quo = quo_q[QBits];
	assign tag_out = tag_q[QBits];
endmodule

// File: src/square_to_concentric_disk_unit.sv
// Top level of the square to concentric disk mapping unit.
// The unit maps a point (u, v) of the unit square, unsigned Q1.15, to the unit disk and
// returns (x, y) in signed Q1.15, one request accepted in every cycle when the output
// side does not stall. The pipeline has one stage for the region choice, 30 bit-per-stage
// divider stages for the ratio, one for the angle and gain product, one for the start
// vector, one per rotation step (the steps capped at 32) and one for the output register.
// A stall freezes the whole pipeline, so a finished result that waits at the output
// holds off new requests until it is taken. Inputs above 1.0 are clamped; results of
// +1.0 saturate to 32767.
module square_to_concentric_disk_unit #(
	parameter int FRAC_BITS = scd_pkg::FracBitsDefault,
	parameter int ROTATION_STEPS = scd_pkg::RotStepsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  scd_pkg::scd_in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output scd_pkg::scd_out_t out_data
);
	import scd_pkg::*;

	localparam int NB = FRAC_BITS + 2;           // signed a, b, r
	localparam int ZB = AngBits + 5;             // angle width, holds a full turn
	localparam int WB = FRAC_BITS + Guard + 3;   // rotator x, y width
	localparam int NS = (ROTATION_STEPS < 32) ? ROTATION_STEPS : 32;
	localparam int TB = NB + 4;                  // tag: r, base, subtract, sign
	localparam logic [NB-1:0] One = NB'(1) << FRAC_BITS;

	// The pipeline advances whenever the output register can take a result.
	logic adv;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Stage 1: clamp, a and b, region choice.
	logic v_s1;
	logic [NB-1:0] num_s1, den_s1, r_s1;
	logic [1:0] base_s1;
	logic sub_s1, neg_s1;
	logic [NB-1:0] s0_r, s0_nm, s0_dn;
	logic [1:0] s0_bs;
	logic s0_sb;

	always_comb begin : s0
		logic [NB-1:0] u, v, a, b, r, nm, dn;
		logic [1:0] bs;
		logic sb;
		u = (in_data.square_u > 16'(One)) ? One : NB'(in_data.square_u);
		v = (in_data.square_v > 16'(One)) ? One : NB'(in_data.square_v);
		a = (u << 1) - One;
		b = (v << 1) - One;
		if ($signed(a) > -$signed(b)) begin
			if ($signed(a) > $signed(b)) begin
				r = a; nm = b; dn = a; bs = 2'd0; sb = 1'b0;
			end else begin
				r = b; nm = a; dn = b; bs = 2'd1; sb = 1'b1;
			end
		end else begin
			if ($signed(a) < $signed(b)) begin
				r = -a; nm = b; dn = a; bs = 2'd2; sb = 1'b0;
			end else begin
				r = -b; nm = a; dn = b; bs = 2'd3; sb = 1'b1;
			end
		end
		if (dn == '0) bs = 2'd0;
		s0_r = r; s0_nm = nm; s0_dn = dn; s0_bs = bs; s0_sb = sb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1 <= s0_r;
			base_s1 <= s0_bs;
			sub_s1 <= s0_sb;
			neg_s1 <= s0_nm[NB-1] ^ s0_dn[NB-1];
			num_s1 <= s0_nm[NB-1] ? -s0_nm : s0_nm;
			den_s1 <= s0_dn[NB-1] ? -s0_dn : s0_dn;
		end
	end

	// Divider: |num| << AngBits / |den|; |num| <= |den| so AngBits+1 bits suffice.
	// A zero divisor gives all-ones, harmless as the radius is then zero.
	logic v_d;
	logic [DivBits-1:0] q_d;
	logic [TB-1:0] tag_d;
	scd_divider #(.NumBits(NB), .QBits(DivBits), .TagBits(TB)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(v_s1),
		.num(num_s1), .den(den_s1),
		.tag_in({r_s1, base_s1, sub_s1, neg_s1}),
		.vout(v_d), .quo(q_d), .tag_out(tag_d)
	);

	// Stage A: angle, quarter pre-rotation, gain product.
	logic v_a;
	logic [ZB-1:0] z_a;
	logic [1:0] quad_a;
	logic [NB+29:0] prod_a;
	logic [ZB-1:0] sa_z;
	logic [1:0] sa_q;
	logic [NB-1:0] sa_r;

	always_comb begin : sa
		logic [ZB-1:0] ratio, phi, k;
		logic [NB-1:0] rr;
		logic [1:0] bs;
		logic sb, ng;
		{rr, bs, sb, ng} = tag_d;
		ratio = ng ? -ZB'(q_d) : ZB'(q_d);
		if (rr == '0) ratio = '0;
		phi = (ZB'(bs) << (AngBits + 1)) + (sb ? -ratio : ratio);
		k = $signed(phi + (ZB'(1) << AngBits)) >>> (AngBits + 1);
		sa_z = phi - (k << (AngBits + 1));
		sa_q = k[1:0];
		sa_r = rr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
		end else if (adv) begin
			v_a <= v_d;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			z_a <= sa_z;
			quad_a <= sa_q;
			prod_a <= (NB + 30)'(sa_r) * (NB + 30)'(GainQ30);
		end
	end

	// Rotator stages, one CORDIC step each.
	logic signed [WB-1:0] x_c [NS+1];
	logic signed [WB-1:0] y_c [NS+1];
	logic signed [ZB-1:0] z_c [NS+1];
	logic v_c [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c[0] <= 1'b0;
		end else if (adv) begin
			v_c[0] <= v_a;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [WB-1:0] m;
			m = WB'(prod_a >> (30 - Guard));
			z_c[0] <= z_a;
			case (quad_a)
				2'd0: begin x_c[0] <= m; y_c[0] <= '0; end
				2'd1: begin x_c[0] <= '0; y_c[0] <= m; end
				2'd2: begin x_c[0] <= -m; y_c[0] <= '0; end
				default: begin x_c[0] <= '0; y_c[0] <= -m; end
			endcase
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_rot
		localparam logic signed [ZB-1:0] Step = ZB'(step_angle(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_c[i+1] <= 1'b0;
			end else if (adv) begin
				v_c[i+1] <= v_c[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_c[i][ZB-1]) begin
					x_c[i+1] <= x_c[i] - (y_c[i] >>> i);
					y_c[i+1] <= y_c[i] + (x_c[i] >>> i);
					z_c[i+1] <= z_c[i] - Step;
				end else begin
					x_c[i+1] <= x_c[i] + (y_c[i] >>> i);
					y_c[i+1] <= y_c[i] - (x_c[i] >>> i);
					z_c[i+1] <= z_c[i] + Step;
				end
			end
		end
	end

	// Output register: round off guard bits, saturate.
	function automatic logic [15:0] fin(input logic signed [WB-1:0] w);
		logic signed [WB-1:0] t;
		logic signed [WB-1:0] top, bot;
		top = (WB'(1) << FRAC_BITS) - WB'(1);
		bot = -(WB'(1) << FRAC_BITS);
		t = (w + WB'(1 << (Guard - 1))) >>> Guard;
		if (t > top) t = top;
		if (t < bot) t = bot;
		return 16'(t);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_c[NS];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.disk_x <= fin(x_c[NS]);
			out_data.disk_y <= fin(y_c[NS]);
		end
	end
endmodule

// File: src/scd_checker.sv
// Port-level checker for the concentric disk mapping unit, bound to the top level.
module scd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input scd_pkg::scd_out_t out_data
);
	import scd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.disk_x != 16'sh8000 || out_data.disk_y != 16'sh8000)
		else $error("result outside disk");
endmodule

bind square_to_concentric_disk_unit scd_checker u_scd_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// File: tb/square_to_concentric_disk_unit_tb.sv
// Self-checking testbench for the square to concentric disk mapping unit.
module square_to_concentric_disk_unit_tb;
	import scd_pkg::*;

	// The pipeline is 50 stages deep, so this many cycles cover a full drain.
	localparam int DrainCycles = 120;
	localparam int Frac = 15;
	localparam int RotSteps = 16;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	scd_in_t in_data;
	logic out_valid;
	logic out_stall;
	scd_out_t out_data;

	// Expected disk points, oldest first.
	scd_out_t disk_expected_q[$];
	int n_fail = 0;
	int n_sent = 0;
	int n_checked = 0;
	// Sender side idling control.
	bit send_gaps = 1;
	// Receiver side control: random stalls, and a long hold-off on request.
	bit recv_gaps = 1;
	int hold_cycles = 0;

	square_to_concentric_disk_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("== FAIL ==");
		$finish;
	end

	// Floor shift of a signed value; >>> on a signed longint already floors.
	function automatic longint fshift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint sat_q(input longint v);
		longint top;
		longint bottom;
		top = (longint'(1) << Frac) - 1;
		bottom = -(longint'(1) << Frac);
		if (v > top) return top;
		if (v < bottom) return bottom;
		return v;
	endfunction

	// Concentric mapping of one square point, done in 64-bit integer arithmetic.
	function automatic scd_out_t map_to_disk(input scd_in_t p);
		longint one, eighth, u, v, a, b, r, num, den, ratio, phi, rem, k, mag;
		longint x, y, z, dx, dy, base, n, d, q;
		bit subtract;
		int quad;
		scd_out_t res;
		one = longint'(1) << Frac;
		eighth = longint'(1) << AngBits;
		u = p.square_u;
		v = p.square_v;
		// Inputs above 1.0 are clamped to 1.0.
		if (u > one) u = one;
		if (v > one) v = one;
		a = 2 * u - one;
		b = 2 * v - one;
		if (a > -b) begin
			if (a > b) begin
				r = a; num = b; den = a; base = 0; subtract = 0;
			end else begin
				r = b; num = a; den = b; base = 2; subtract = 1;
			end
		end else begin
			if (a < b) begin
				r = -a; num = b; den = a; base = 4; subtract = 0;
			end else begin
				r = -b; num = a; den = b; base = 6; subtract = 1;
			end
		end
		ratio = 0;
		// At the origin the divisor is zero and the angle is taken as zero.
		if (den != 0) begin
			n = (num < 0) ? -num : num;
			d = (den < 0) ? -den : den;
			q = (n << AngBits) / d;
			ratio = ((num < 0) != (den < 0)) ? -q : q;
		end else begin
			base = 0;
		end
		phi = base * eighth + (subtract ? -ratio : ratio);
		// Quarter-turn pre-rotation leaves a residual in [-1/8, 1/8) of a turn.
		k = (phi + eighth) >>> (AngBits + 1);
		rem = phi - k * 2 * eighth;
		quad = int'(k & 3);
		mag = (r * longint'(GainQ30)) >>> (30 - Guard);
		case (quad)
			0: begin x = mag; y = 0; end
			1: begin x = 0; y = mag; end
			2: begin x = -mag; y = 0; end
			default: begin x = 0; y = -mag; end
		endcase
		z = rem;
		for (int i = 0; i < RotSteps && i < 32; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(step_angle(i));
			end else begin
				x += dx; y -= dy; z += longint'(step_angle(i));
			end
		end
		x = sat_q(fshift(x + (longint'(1) << (Guard - 1)), Guard));
		y = sat_q(fshift(y + (longint'(1) << (Guard - 1)), Guard));
		res.disk_x = x[15:0];
		res.disk_y = y[15:0];
		return res;
	endfunction

	// Offers one request, optionally after a random gap, and holds it until taken.
	task automatic send_point(input logic [15:0] u, input logic [15:0] v);
		scd_in_t p;
		int gap;
		p.square_u = u;
		p.square_v = v;
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// The request was accepted at this edge; record what it should give.
		disk_expected_q.push_back(map_to_disk(p));
		n_sent++;
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		go_idle();
		while (disk_expected_q.size() != 0) @(posedge clk);
	endtask

	// Random coordinate: mostly in range, sometimes the edges, near the centre or above 1.0.
	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 16'(32768);
			1: return 16'd0;
			2: return 16'(16384 + $urandom_range(0, 2) - 1);
			3: return 16'($urandom_range(32769, 65535));
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	// Receiver: random stall bursts, or a long hold-off when one is requested.
	initial begin
		int burst;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 14);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Checker: every accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		scd_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (disk_expected_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d", $time,
					out_data.disk_x, out_data.disk_y);
				n_fail++;
			end else begin
				want = disk_expected_q.pop_front();
				if (out_data.disk_x !== want.disk_x) begin
					$display("%0t: disk_x expected %0d actual %0d", $time,
						want.disk_x, out_data.disk_x);
					n_fail++;
				end
				if (out_data.disk_y !== want.disk_y) begin
					$display("%0t: disk_y expected %0d actual %0d", $time,
						want.disk_y, out_data.disk_y);
					n_fail++;
				end
				n_checked++;
			end
		end
	end

	// Corners, edges, centre, region boundaries and points above 1.0.
	task automatic test_special_points();
		send_point(16'd0, 16'd0);
		send_point(16'd32768, 16'd32768);
		send_point(16'd0, 16'd32768);
		send_point(16'd32768, 16'd0);
		send_point(16'd16384, 16'd16384);
		send_point(16'd16384, 16'd32768);
		send_point(16'd16384, 16'd0);
		send_point(16'd0, 16'd16384);
		send_point(16'd32768, 16'd16384);
		send_point(16'd65535, 16'd65535);
		send_point(16'd32769, 16'd16384);
		send_point(16'd24576, 16'd24576);
		send_point(16'd8192, 16'd24576);
		send_point(16'd8192, 16'd8192);
		send_point(16'd24576, 16'd8192);
		send_point(16'd16385, 16'd16384);
		send_point(16'd16383, 16'd16384);
		send_point(16'd16384, 16'd16383);
		send_point(16'd16384, 16'd16385);
		send_point(16'd32767, 16'd1);
		send_point(16'd21845, 16'd65535);
		wait_drained();
	endtask

	task automatic test_random_points(input int count);
		for (int i = 0; i < count; i++) send_point(rand_coord(), rand_coord());
	endtask

	// The receiver holds off long enough for the pipeline to fill and stall the input.
	task automatic test_backpressure();
		hold_cycles = 400;
		test_random_points(120);
		wait_drained();
	endtask

	// Back-to-back requests with no idling on either side.
	task automatic test_full_rate(input int count);
		send_gaps = 0;
		recv_gaps = 0;
		test_random_points(count);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_points();
		test_random_points(900);
		// The sender pauses here until every result has come back.
		wait_drained();
		test_backpressure();
		test_random_points(600);
		wait_drained();
		test_full_rate(400);
		repeat (DrainCycles) @(posedge clk);
		$display("Sent %0d square points, checked %0d disk points,", n_sent, n_checked);
		$display("with stall bursts, a long output hold-off and a full-rate stretch.");
		if (n_fail == 0 && disk_expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
